// ===== hdl/tiled_fixed_point_matmul_top_defines.svh =====
// assertion macros for the matrix product engine
`ifndef TILED_FIXED_POINT_MATMUL_TOP_DEFINES_SVH
`define TILED_FIXED_POINT_MATMUL_TOP_DEFINES_SVH

`ifndef SYNTH
`define TFPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TFPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TFPM_ASSERT_SAME(lbl, ante, cons, msg)
`define TFPM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/tfpm_pkg.sv =====
package tfpm_pkg;

  localparam int MAX_DIM   = 32;
  localparam int TILE      = 32;
  localparam int FRAC_BITS = 16;

  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int KW     = $clog2(MAX_DIM + 1);
  localparam int TW     = $clog2(TILE + 1);

  localparam logic [1:0] FN_WRITE_A = 2'd0;
  localparam logic [1:0] FN_WRITE_B = 2'd1;
  localparam logic [1:0] FN_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] product_value;
    logic [4:0]         out_row;
    logic [4:0]         out_col;
  } out_word_t;

  typedef struct packed {
    logic chunk_end;
    logic last;
  } tag_t;

endpackage

// ===== hdl/tfpm_ram.sv =====
module tfpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tiled_fixed_point_matmul_top.sv =====
// Q16.16 matrix product engine. A word with func write A or write B stores one element and
// is taken every cycle in which busy is low, and it does not raise busy. A compute word for
// (row, column) walks the inner dimension one stored A/B pair per cycle through the two
// store RAMs, and the pairs then pass through RAM read and multiply, chunk sum, final add
// and the output register. busy is high from acceptance until the output register is loaded,
// so the next word is taken at the earliest on the edge that takes the result. A compute
// with a zero inner length or an index beyond the store gives a zero result in the cycle
// after acceptance without raising busy. out_valid is high for exactly one cycle per result
// and the result must be captured then: there is no way to hold it off. inner_len
// may be written only while busy is low and no result is pending; values above the store
// size use the full size.
`include "tiled_fixed_point_matmul_top_defines.svh"

module tiled_fixed_point_matmul_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tfpm_pkg::in_word_t  in_word,
  output logic                out_valid,
  output tfpm_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata
);

  import tfpm_pkg::*;

  logic [5:0]        inner_len_r;
  logic [KW-1:0]     klen;
  logic              accept;
  logic              in_range;
  logic              launch;
  logic              wr_a, wr_b;
  logic [ADDR_W-1:0] waddr;

  logic              busy_r, issue_r;
  logic [KW-1:0]     k_r;
  logic [TW-1:0]     tc_r;
  logic [4:0]        row_r, col_r;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [31:0]       rd_a, rd_b;
  tag_t              tag_issue;

  logic              v1_r, v2_r, v3_r;
  tag_t              tag1_r, tag2_r, tag3_r;
  logic signed [63:0] prod;
  logic signed [63:0] prod_r;
  logic [63:0]       csum_r, csum_nxt;
  logic [31:0]       chunk_r;
  logic [31:0]       acc_r, acc_nxt;
  logic              out_valid_r;
  out_word_t         out_word_r;

  assign klen = (int'(inner_len_r) > MAX_DIM) ? KW'(MAX_DIM) : KW'(inner_len_r);

  assign accept   = start && !busy_r;
  assign in_range = (int'(in_word.row_index) < MAX_DIM) && (int'(in_word.col_index) < MAX_DIM);
  assign launch   = accept && (in_word.func == FN_COMPUTE) && in_range && (klen != '0);
  assign wr_a     = accept && in_range && (in_word.func == FN_WRITE_A);
  assign wr_b     = accept && in_range && (in_word.func == FN_WRITE_B);
  assign waddr    = ADDR_W'(int'(in_word.row_index) * MAX_DIM + int'(in_word.col_index));

  // A[row][k] and B[k][col]
  assign raddr_a = ADDR_W'(int'(row_r) * MAX_DIM + int'(k_r));
  assign raddr_b = ADDR_W'(int'(k_r) * MAX_DIM + int'(col_r));

  assign tag_issue.last      = (k_r == klen - KW'(1));
  assign tag_issue.chunk_end = (tc_r == TW'(TILE - 1)) || tag_issue.last;

  tfpm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (wr_a),
    .waddr (waddr),
    .wdata (in_word.value),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  tfpm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (wr_b),
    .waddr (waddr),
    .wdata (in_word.value),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  assign prod     = $signed(rd_a) * $signed(rd_b);
  assign csum_nxt = csum_r + prod_r;
  assign acc_nxt  = acc_r + chunk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_len_r <= 6'd32;
    end else if (cfg_we) begin
      inner_len_r <= cfg_wdata;
    end
  end

  // issue side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      k_r     <= '0;
      tc_r    <= '0;
    end else if (launch) begin
      issue_r <= 1'b1;
      k_r     <= '0;
      tc_r    <= '0;
    end else if (issue_r) begin
      k_r  <= k_r + KW'(1);
      tc_r <= tag_issue.chunk_end ? '0 : tc_r + TW'(1);
      if (tag_issue.last) begin
        issue_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_r <= in_word.row_index;
      col_r <= in_word.col_index;
    end
  end

  // pipeline valids and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      csum_r      <= '0;
      acc_r       <= '0;
    end else begin
      v1_r        <= issue_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r && tag2_r.chunk_end;
      out_valid_r <= 1'b0;
      if (accept && in_word.func == FN_COMPUTE) begin
        csum_r <= '0;
        acc_r  <= '0;
        if (in_range && klen != '0) begin
          busy_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end
      if (v2_r) begin
        csum_r <= tag2_r.chunk_end ? '0 : csum_nxt;
      end
      if (v3_r) begin
        if (tag3_r.last) begin
          acc_r       <= '0;
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end else begin
          acc_r <= acc_nxt;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    tag1_r <= tag_issue;
    tag2_r <= tag1_r;
    prod_r <= prod;
    if (v2_r) begin
      tag3_r <= tag2_r;
      if (tag2_r.chunk_end) begin
        // arithmetic shift by the fraction bits, truncated to 32
        chunk_r <= csum_nxt[FRAC_BITS +: 32];
      end
    end
    if (accept && in_word.func == FN_COMPUTE) begin
      out_word_r.product_value <= '0;
      out_word_r.out_row       <= in_word.row_index;
      out_word_r.out_col       <= in_word.col_index;
    end
    if (v3_r && tag3_r.last) begin
      out_word_r.product_value <= acc_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `TFPM_ASSERT_SAME(a_idle_empty, !busy_r, !(issue_r || v1_r || v2_r || v3_r), "active while idle")
  `TFPM_ASSERT_NEXT(a_last_done, v3_r && tag3_r.last, !busy_r && out_valid_r, "no result")
  `TFPM_ASSERT_SAME(a_no_write_busy, busy_r, !wr_a && !wr_b, "store written during compute")
  `TFPM_ASSERT_NEXT(a_launch, launch, issue_r && busy_r && k_r == '0, "no issue after compute")

endmodule
